// File: hw/rtl/glb_pkg.sv
`default_nettype none

package glb_pkg;

	localparam int unsigned MaxWords = 64;
	localparam int unsigned IdxW = $clog2(MaxWords);
	localparam int unsigned CntW = $clog2(MaxWords + 1);

	localparam logic [1:0] CMD_WORD  = 2'd0;
	localparam logic [1:0] CMD_SPACE = 2'd1;
	localparam logic [1:0] CMD_PARA  = 2'd2;
	localparam logic [1:0] CMD_FLUSH = 2'd3;

	localparam logic [2:0] REG_CONTENT_WIDTH = 3'd0;
	localparam logic [2:0] REG_LEFT_MARGIN   = 3'd1;
	localparam logic [2:0] REG_TOP_MARGIN    = 3'd2;
	localparam logic [2:0] REG_BOTTOM_LIMIT  = 3'd3;
	localparam logic [2:0] REG_LINE_HEIGHT   = 3'd4;
	localparam logic [2:0] REG_SPACE_WIDTH   = 3'd5;
	localparam logic [2:0] REG_ALIGNMENT     = 3'd6;

	localparam logic [1:0] ALIGN_LEFT = 2'd0;
	localparam logic [1:0] ALIGN_MID  = 2'd1;
	localparam logic [1:0] ALIGN_END  = 2'd2;

	localparam logic [11:0] RST_CONTENT_WIDTH = 12'd400;
	localparam logic [11:0] RST_LEFT_MARGIN   = 12'd0;
	localparam logic [11:0] RST_TOP_MARGIN    = 12'd0;
	localparam logic [12:0] RST_BOTTOM_LIMIT  = 13'd800;
	localparam logic [9:0]  RST_LINE_HEIGHT   = 10'd20;
	localparam logic [7:0]  RST_SPACE_WIDTH   = 8'd5;
	localparam logic [1:0]  RST_ALIGNMENT     = ALIGN_LEFT;

	// One stored word of the line buffer.
	typedef struct packed {
		logic [15:0] tag;
		logic [11:0] width;
	} glb_entry_t;

	// Line close request from the control to the emitter.
	typedef struct packed {
		logic            valid;
		logic            blank;
		logic [CntW-1:0] count;
		logic [15:0]     x0;
		logic [13:0]     y;
		logic            pend;
	} glb_start_t;

	// One result as it waits in the output queue.
	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] x;
		logic [13:0] y;
		logic        blank;
		logic        last;
		logic        pend;
	} glb_out_t;

endpackage

`default_nettype wire

// File: hw/rtl/greedy_line_breaker.sv
// A word that fits on the open line is taken and written to the line buffer.
// A closed line passes the start state, a buffer read and the output queue; results then
// come one per cycle while m_tready is high. The buffer's single read port sets the pace.
// Input is held off while a closed line is being read out of the buffer.
// Reset (arst_n low, asynchronous) restores register defaults, empties the line and puts
// y at the top margin; the buffer contents are not cleared.
`default_nettype none

module greedy_line_breaker
	import glb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // word_width[11:0], word_tag[27:12], zero[31:28]
	input  wire logic [1:0]  s_tuser,   // cmd[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // word_tag_res[15:0], x_pos[31:16], y_pos[45:32], zero
	output logic             m_tlast,
	output logic [1:0]       m_tuser,   // blank_line[0], page_end[1]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [12:0] cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [11:0] content_width_q;
	logic [11:0] left_margin_q;
	logic [11:0] top_margin_q;
	logic [12:0] bottom_limit_q;
	logic [9:0]  line_height_q;
	logic [7:0]  space_width_q;
	logic [1:0]  alignment_q;

	logic [1:0]      state_q;
	logic [CntW-1:0] cnt_q;
	logic [12:0]     sum_q;
	logic [13:0]     y_q;
	logic            pend_q;
	logic [11:0]     pw_q;
	logic [15:0]     ptag_q;

	logic [1:0]  cmd;
	logic [11:0] word_width;
	logic [15:0] word_tag;
	logic        accept;
	logic [13:0] need;
	logic        overflow;
	logic        add_now;
	logic        emit_busy;

	logic        ram_we;
	logic [IdxW-1:0] ram_waddr;
	glb_entry_t  ram_wdata;
	logic        ram_re;
	logic [IdxW-1:0] ram_raddr;
	glb_entry_t  ram_rdata;

	logic signed [13:0] diff;
	logic signed [13:0] off;
	logic [14:0] ny;
	logic        wrap;
	logic [13:0] y_next;
	glb_start_t  start;
	glb_out_t    out_item;

	assign cmd        = s_tuser;
	assign word_width = s_tdata[11:0];
	assign word_tag   = s_tdata[27:12];

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign need     = {1'b0, sum_q} + {6'd0, space_width_q} + {2'd0, word_width};
	assign overflow = (cnt_q != '0) && (need > {2'd0, content_width_q});
	assign add_now  = accept && (cmd == CMD_WORD) && !overflow;

	// Alignment offset; the center case halves toward zero.
	assign diff = $signed({2'd0, content_width_q}) - $signed({1'b0, sum_q});
	always_comb begin
		case (alignment_q)
			ALIGN_MID: off = (diff + $signed({13'd0, diff[13]})) >>> 1;
			ALIGN_END: off = diff;
			default:   off = '0;
		endcase
	end

	assign ny     = {1'b0, y_q} + {5'd0, line_height_q};
	assign wrap   = (ny >= {2'd0, bottom_limit_q});
	assign y_next = wrap ? {2'd0, top_margin_q} : ny[13:0];

	always_comb begin
		start.valid = (state_q == ST_START);
		start.blank = (cnt_q == '0);
		start.count = (cnt_q == '0) ? CntW'(1) : cnt_q;
		start.x0    = (cnt_q == '0) ? {4'd0, left_margin_q}
		                            : {4'd0, left_margin_q} + {{2{off[13]}}, off};
		start.y     = y_q;
		start.pend  = wrap;
	end

	always_comb begin
		if (state_q == ST_DRAIN) begin
			ram_we          = !emit_busy && pend_q;
			ram_waddr       = '0;
			ram_wdata.tag   = ptag_q;
			ram_wdata.width = pw_q;
		end else begin
			ram_we          = add_now;
			ram_waddr       = cnt_q[IdxW-1:0];
			ram_wdata.tag   = word_tag;
			ram_wdata.width = word_width;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			content_width_q <= RST_CONTENT_WIDTH;
			left_margin_q   <= RST_LEFT_MARGIN;
			top_margin_q    <= RST_TOP_MARGIN;
			bottom_limit_q  <= RST_BOTTOM_LIMIT;
			line_height_q   <= RST_LINE_HEIGHT;
			space_width_q   <= RST_SPACE_WIDTH;
			alignment_q     <= RST_ALIGNMENT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CONTENT_WIDTH: content_width_q <= cfg_data[11:0];
				REG_LEFT_MARGIN:   left_margin_q   <= cfg_data[11:0];
				REG_TOP_MARGIN:    top_margin_q    <= cfg_data[11:0];
				REG_BOTTOM_LIMIT:  bottom_limit_q  <= cfg_data;
				REG_LINE_HEIGHT:   line_height_q   <= cfg_data[9:0];
				REG_SPACE_WIDTH:   space_width_q   <= cfg_data[7:0];
				REG_ALIGNMENT:     alignment_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sum_q   <= '0;
			y_q     <= {2'd0, RST_TOP_MARGIN};
			pend_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_WORD: begin
								if (overflow) begin
									// The word opens the next line once this one is out.
									pend_q  <= 1'b1;
									state_q <= ST_START;
								end else begin
									cnt_q <= cnt_q + CntW'(1);
									sum_q <= (cnt_q != '0) ? need[12:0] : {1'b0, word_width};
									if (cnt_q == CntW'(MaxWords - 1)) begin
										pend_q  <= 1'b0;
										state_q <= ST_START;
									end
								end
							end
							CMD_SPACE: ;
							default: begin
								pend_q  <= 1'b0;
								state_q <= ST_START;
							end
						endcase
					end
				end
				ST_START: begin
					y_q     <= y_next;
					cnt_q   <= '0;
					sum_q   <= '0;
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!emit_busy) begin
						if (pend_q) begin
							cnt_q  <= CntW'(1);
							sum_q  <= {1'b0, pw_q};
							pend_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && overflow && (cmd == CMD_WORD)) begin
			pw_q   <= word_width;
			ptag_q <= word_tag;
		end
	end

	glb_line_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	glb_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.space_width (space_width_q),
		.busy        (emit_busy),
		.rd_en       (ram_re),
		.rd_addr     (ram_raddr),
		.rd_data     (ram_rdata),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_item    (out_item)
	);

	assign m_tdata = {2'd0, out_item.y, out_item.x, out_item.tag};
	assign m_tlast = out_item.last;
	assign m_tuser = {out_item.pend, out_item.blank};

endmodule

`default_nettype wire

// File: hw/rtl/glb_line_ram.sv
`default_nettype none

module glb_line_ram
	import glb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       we,
	input  wire logic [IdxW-1:0] waddr,
	input  wire glb_entry_t wdata,
	input  wire logic       re,
	input  wire logic [IdxW-1:0] raddr,
	output glb_entry_t      rdata
);

	glb_entry_t mem [MaxWords];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/glb_emit.sv
`default_nettype none

module glb_emit
	import glb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire glb_start_t  start,
	input  wire logic [7:0]  space_width,
	output logic             busy,
	output logic             rd_en,
	output logic [IdxW-1:0]  rd_addr,
	input  wire glb_entry_t  rd_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output glb_out_t         out_item
);

	logic            act_q;
	logic [CntW-1:0] idx_q;
	logic [CntW-1:0] cnt_q;
	logic            blank_q;
	logic [13:0]     y_q;
	logic            pend_q;
	logic [15:0]     cx_q;
	logic            rd_s1;
	logic            last_s1;

	glb_out_t        fifo_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      fcnt_q;

	logic            pop;
	logic [1:0]      occ;
	logic            issue;
	logic            last_issue;
	glb_out_t        item;

	assign pop        = (fcnt_q != 2'd0) && out_ready;
	assign occ        = fcnt_q + {1'b0, rd_s1};
	// A read is issued only when its result is sure to find room in the queue.
	assign issue      = act_q && ((occ < 2'd2) || pop);
	assign last_issue = (idx_q == (cnt_q - CntW'(1)));
	assign rd_en      = issue && !blank_q;
	assign rd_addr    = idx_q[IdxW-1:0];
	assign busy       = act_q | rd_s1;

	always_comb begin
		item.tag   = blank_q ? 16'd0 : rd_data.tag;
		item.x     = cx_q;
		item.y     = y_q;
		item.blank = blank_q;
		item.last  = last_s1;
		item.pend  = pend_q;
	end

	assign out_valid = (fcnt_q != 2'd0);
	assign out_item  = fifo_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			idx_q  <= '0;
			rd_s1  <= 1'b0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fcnt_q <= 2'd0;
		end else begin
			if (start.valid) begin
				act_q <= 1'b1;
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CntW'(1);
				if (last_issue) begin
					act_q <= 1'b0;
				end
			end
			rd_s1 <= issue;
			if (rd_s1) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			fcnt_q <= fcnt_q + {1'b0, rd_s1} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (start.valid) begin
			cnt_q   <= start.count;
			blank_q <= start.blank;
			y_q     <= start.y;
			pend_q  <= start.pend;
			cx_q    <= start.x0;
		end else if (rd_s1) begin
			cx_q <= cx_q + {4'd0, rd_data.width} + {8'd0, space_width};
		end
		last_s1 <= last_issue;
		if (rd_s1) begin
			fifo_q[wptr_q] <= item;
		end
	end

endmodule

`default_nettype wire
